### hdl/gda_pkg.sv
// Shared types, codes and calendar functions for the Gregorian date arithmetic unit.
package gda_pkg;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_SUB     = 2'd1;
    localparam logic [1:0] OP_BETWEEN = 2'd2;
    localparam logic [1:0] OP_LATER   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MONTH = 2'd1;
    localparam logic [1:0] ST_BAD_DAY   = 2'd2;
    localparam logic [1:0] ST_BAD_YEAR  = 2'd3;

    localparam int unsigned MAX_OFFSET_DAYS = 65535;

    localparam logic [11:0] YEAR_MIN = 12'd1900;
    localparam logic [11:0] YEAR_MAX = 12'd2100;

    // Multiplicative inverse of 25 modulo 4096; a 12-bit year is a multiple of 25
    // exactly when its product with the inverse, modulo 4096, is at most 163.
    localparam logic [11:0] INV25     = 12'd3113;
    localparam logic [11:0] DIV25_MAX = 12'd163;

    typedef struct packed {
        logic load;
        logic init;
        logic add_step;
        logic sub_step;
        logic month_step;
        logic serial_step;
        logic finish;
    } gda_cmd_t;

    typedef struct packed {
        logic       bad;
        logic [1:0] op;
        logic       add_done;
        logic       sub_done;
        logic       month_done;
        logic       serial_done;
    } gda_sts_t;

    function automatic logic leap_year(input logic [11:0] y);
        logic [23:0] prod;
        logic        div25;
        prod  = {12'b0, y} * {12'b0, INV25};
        div25 = (prod[11:0] <= DIV25_MAX);
        return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] check_date(
        input logic [4:0]  d,
        input logic [3:0]  m,
        input logic [11:0] y
    );
        logic [4:0] len;
        logic [1:0] st;
        len = month_len(m, leap_year(y));
        if (m == 4'd0 || m > 4'd12) begin
            st = ST_BAD_MONTH;
        end else if (d == 5'd0 || d > len) begin
            st = ST_BAD_DAY;
        end else if (y < YEAR_MIN || y > YEAR_MAX) begin
            st = ST_BAD_YEAR;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

### hdl/gda_datapath.sv
// Datapath of the date unit: request registers, year and month stepping, day counts and result registers.
module gda_datapath (
    input  logic               aclk,
    input  gda_pkg::gda_cmd_t  cmd,
    output gda_pkg::gda_sts_t  sts,
    input  logic [1:0]         s_req_type,
    input  logic [4:0]         s_first_day,
    input  logic [3:0]         s_first_month,
    input  logic [11:0]        s_first_year,
    input  logic [4:0]         s_second_day,
    input  logic [3:0]         s_second_month,
    input  logic [11:0]        s_second_year,
    input  logic [15:0]        s_day_offset,
    input  logic               aresetn,
    output logic [4:0]         m_out_day,
    output logic [3:0]         m_out_month,
    output logic [11:0]        m_out_year,
    output logic [16:0]        m_day_distance,
    output logic               m_is_later,
    output logic [1:0]         m_status
);
    import gda_pkg::*;

    logic [1:0]  op_reg;
    logic [4:0]  d1_reg, d2_reg;
    logic [3:0]  m1_reg, m2_reg;
    logic [11:0] y1_reg, y2_reg;
    logic [15:0] rem_reg;
    logic [1:0]  status_reg;
    logic [11:0] ycur_reg;
    logic [8:0]  doy_reg;
    logic [3:0]  mon_reg;
    logic [16:0] acc1_reg, acc2_reg;

    logic [4:0]  out_day_reg;
    logic [3:0]  out_month_reg;
    logic [11:0] out_year_reg;
    logic [16:0] day_distance_reg;
    logic        is_later_reg;
    logic [1:0]  out_status_reg;

    logic [15:0] off_sat;
    logic [1:0]  st1, st2, status_comb;
    logic        leap1, leap2, leapc, leapp;
    logic [11:0] yprev;
    logic [8:0]  doy1, doy2;
    logic [8:0]  ylenc, ylenp, left;
    logic [8:0]  ml;
    logic [11:0] ymax;
    logic        add_more, sub_more, month_more, serial_more;

    always_comb begin
        off_sat = (32'(s_day_offset) > MAX_OFFSET_DAYS) ? 16'(MAX_OFFSET_DAYS) : s_day_offset;

        st1 = check_date(d1_reg, m1_reg, y1_reg);
        st2 = check_date(d2_reg, m2_reg, y2_reg);
        if (st1 != ST_OK) begin
            status_comb = st1;
        end else if (op_reg == OP_BETWEEN || op_reg == OP_LATER) begin
            status_comb = st2;
        end else begin
            status_comb = ST_OK;
        end

        leap1 = leap_year(y1_reg);
        leap2 = leap_year(y2_reg);
        leapc = leap_year(ycur_reg);
        yprev = ycur_reg - 12'd1;
        leapp = leap_year(yprev);

        doy1 = month_start(m1_reg) + 9'((m1_reg > 4'd2) && leap1) + {4'b0, d1_reg} - 9'd1;
        doy2 = month_start(m2_reg) + 9'((m2_reg > 4'd2) && leap2) + {4'b0, d2_reg} - 9'd1;

        ylenc = leapc ? 9'd366 : 9'd365;
        ylenp = leapp ? 9'd366 : 9'd365;
        left  = ylenc - doy_reg;
        ml    = {4'b0, month_len(mon_reg, leapc)};
        ymax  = (y1_reg > y2_reg) ? y1_reg : y2_reg;

        add_more    = ({7'b0, left} <= rem_reg);
        sub_more    = (rem_reg > {7'b0, doy_reg});
        month_more  = (doy_reg >= ml);
        serial_more = (ycur_reg < ymax);

        sts.bad         = (status_comb != ST_OK);
        sts.op          = op_reg;
        sts.add_done    = !add_more;
        sts.sub_done    = !sub_more;
        sts.month_done  = !month_more;
        sts.serial_done = !serial_more;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_req_type;
            d1_reg  <= s_first_day;
            m1_reg  <= s_first_month;
            y1_reg  <= s_first_year;
            d2_reg  <= s_second_day;
            m2_reg  <= s_second_month;
            y2_reg  <= s_second_year;
            rem_reg <= off_sat;
        end
        if (cmd.init) begin
            status_reg <= status_comb;
            mon_reg    <= 4'd1;
            doy_reg    <= doy1;
            acc1_reg   <= {8'b0, doy1};
            acc2_reg   <= {8'b0, doy2};
            ycur_reg   <= (op_reg == OP_ADD || op_reg == OP_SUB) ? y1_reg : YEAR_MIN;
        end
        if (cmd.add_step) begin
            if (add_more) begin
                rem_reg  <= rem_reg - {7'b0, left};
                ycur_reg <= ycur_reg + 12'd1;
                doy_reg  <= 9'd0;
            end else begin
                doy_reg <= doy_reg + rem_reg[8:0];
            end
        end
        if (cmd.sub_step) begin
            if (sub_more) begin
                rem_reg  <= rem_reg - ({7'b0, doy_reg} + 16'd1);
                ycur_reg <= yprev;
                doy_reg  <= ylenp - 9'd1;
            end else begin
                doy_reg <= doy_reg - rem_reg[8:0];
            end
        end
        if (cmd.month_step && month_more) begin
            doy_reg <= doy_reg - ml;
            mon_reg <= mon_reg + 4'd1;
        end
        if (cmd.serial_step && serial_more) begin
            if (ycur_reg < y1_reg) begin
                acc1_reg <= acc1_reg + {8'b0, ylenc};
            end
            if (ycur_reg < y2_reg) begin
                acc2_reg <= acc2_reg + {8'b0, ylenc};
            end
            ycur_reg <= ycur_reg + 12'd1;
        end
        if (cmd.finish) begin
            out_day_reg      <= 5'd0;
            out_month_reg    <= 4'd0;
            out_year_reg     <= 12'd0;
            day_distance_reg <= 17'd0;
            is_later_reg     <= 1'b0;
            out_status_reg   <= status_reg;
            if (status_reg == ST_OK) begin
                case (op_reg)
                    OP_ADD, OP_SUB: begin
                        out_day_reg   <= doy_reg[4:0] + 5'd1;
                        out_month_reg <= mon_reg;
                        out_year_reg  <= ycur_reg;
                    end
                    OP_BETWEEN: begin
                        day_distance_reg <= (acc1_reg > acc2_reg) ? acc1_reg - acc2_reg
                                                                  : acc2_reg - acc1_reg;
                    end
                    default: begin
                        is_later_reg <= (acc1_reg > acc2_reg);
                    end
                endcase
            end
        end
    end

    assign m_out_day      = out_day_reg;
    assign m_out_month    = out_month_reg;
    assign m_out_year     = out_year_reg;
    assign m_day_distance = day_distance_reg;
    assign m_is_later     = is_later_reg;
    assign m_status       = out_status_reg;

    // The month walk always starts from January and stops before it leaves December.
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.month_step |-> (mon_reg >= 4'd1 && mon_reg <= 4'd12))
        else $error("month counter out of range during month walk");

endmodule

### hdl/gda_ctrl.sv
// Controller state machine that sequences validation, year and month stepping and result hand-off.
module gda_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output gda_pkg::gda_cmd_t  cmd,
    input  gda_pkg::gda_sts_t  sts
);
    import gda_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INIT     = 3'd1;
    localparam logic [2:0] S_ADD_YEAR = 3'd2;
    localparam logic [2:0] S_SUB_YEAR = 3'd3;
    localparam logic [2:0] S_MONTH    = 3'd4;
    localparam logic [2:0] S_SERIAL   = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init = 1'b1;
                if (sts.bad) begin
                    state_next = S_DONE;
                end else if (sts.op == OP_ADD) begin
                    state_next = S_ADD_YEAR;
                end else if (sts.op == OP_SUB) begin
                    state_next = S_SUB_YEAR;
                end else begin
                    state_next = S_SERIAL;
                end
            end
            S_ADD_YEAR: begin
                cmd.add_step = 1'b1;
                if (sts.add_done) begin
                    state_next = S_MONTH;
                end
            end
            S_SUB_YEAR: begin
                cmd.sub_step = 1'b1;
                if (sts.sub_done) begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH: begin
                cmd.month_step = 1'b1;
                if (sts.month_done) begin
                    state_next = S_DONE;
                end
            end
            S_SERIAL: begin
                cmd.serial_step = 1'b1;
                if (sts.serial_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_INIT))
        else $error("input transfer did not start a request");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before its transfer");

    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("result valid raised without a finished request");

endmodule

### hdl/gregorian_date_arithmetic_unit.sv
// Top level of the Gregorian date arithmetic unit: controller and datapath.
// Each request is handled alone: after an input transfer the unit checks the dates, then
// steps one year per cycle and, for add and subtract, afterwards one month per cycle in a
// single adder/compare datapath. Add and subtract step over the year boundaries that the
// offset crosses (up to about 180 for the largest offset) and then over the months up to
// the month of the result; days-between and compare step over the years from 1900 up to
// the later year. A date that fails its check skips all stepping and goes straight to the
// result. The next request is taken while a finished result still waits in the output
// register.
module gregorian_date_arithmetic_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [4:0]  s_first_day,
    input  logic [3:0]  s_first_month,
    input  logic [11:0] s_first_year,
    input  logic [4:0]  s_second_day,
    input  logic [3:0]  s_second_month,
    input  logic [11:0] s_second_year,
    input  logic [15:0] s_day_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_out_day,
    output logic [3:0]  m_out_month,
    output logic [11:0] m_out_year,
    output logic [16:0] m_day_distance,
    output logic        m_is_later,
    output logic [1:0]  m_status
);
    import gda_pkg::*;

    gda_cmd_t cmd;
    gda_sts_t sts;

    gda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    gda_datapath u_datapath (
        .aclk           (aclk),
        .cmd            (cmd),
        .sts            (sts),
        .s_req_type     (s_req_type),
        .s_first_day    (s_first_day),
        .s_first_month  (s_first_month),
        .s_first_year   (s_first_year),
        .s_second_day   (s_second_day),
        .s_second_month (s_second_month),
        .s_second_year  (s_second_year),
        .s_day_offset   (s_day_offset),
        .aresetn        (aresetn),
        .m_out_day      (m_out_day),
        .m_out_month    (m_out_month),
        .m_out_year     (m_out_year),
        .m_day_distance (m_day_distance),
        .m_is_later     (m_is_later),
        .m_status       (m_status)
    );

endmodule
